// File: sv/bdpc_pkg.sv
package bdpc_pkg;

  // Width of the threshold and window registers
  localparam int unsigned CfgW = 16;

  // Default width of the debounce and press-duration counters
  localparam int unsigned CountBitsDef = 16;

  // Configuration port
  localparam int unsigned CfgIdxW = 8;

  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE_TICKS   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS_TICKS = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CFG_XLONG_PRESS_TICKS = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CFG_ACTIVE_LEVEL     = CfgIdxW'(3);

  // Register values after reset
  localparam logic [CfgW-1:0] DEBOUNCE_TICKS_RST   = CfgW'(10);
  localparam logic [CfgW-1:0] LONG_PRESS_TICKS_RST = CfgW'(900);
  localparam logic [CfgW-1:0] XLONG_PRESS_TICKS_RST = CfgW'(3000);
  localparam logic            ACTIVE_LEVEL_RST     = 1'b0;

  // Stream widths, padded to whole bytes
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 8;

  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_SHORT = 2'd1,
    CLS_LONG  = 2'd2,
    CLS_XLONG = 2'd3
  } press_class_e;

endpackage

// File: sv/button_debounce_press_classifier.sv
// Channel    | Direction | Handshake                  | Payload
// s_axis     | in        | s_axis_tvalid/s_axis_tready | tdata[0] raw_level
// m_axis     | out       | m_axis_tvalid/m_axis_tready | tdata[1:0] press_class
// cfg        | in        | cfg_valid_i/cfg_ready_o     | cfg_index_i, cfg_data_i
//
// One tick a cycle while m_axis does not stall: the state update and classification are done in the
// accepting cycle, the class is registered at the accepting edge and is shown
// on m_axis from the next cycle.
// Throughput is set by the output register alone: a new tick is taken whenever
// that register is empty or being emptied in the same cycle.
// Reset clears the state and the output valid flag and loads the default settings.
// A stall on m_axis holds the class and stops s_axis; cfg is always ready.
module button_debounce_press_classifier #(
  parameter int unsigned COUNT_BITS = bdpc_pkg::CountBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // slave stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [bdpc_pkg::InDataW-1:0]  s_axis_tdata,   // [0] raw_level, rest zero
  // master stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [bdpc_pkg::OutDataW-1:0] m_axis_tdata,   // [1:0] press_class, rest zero
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bdpc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bdpc_pkg::CfgW-1:0]     cfg_data_i
);

  // Compare width covers both the counters and the 16-bit thresholds
  localparam int unsigned CmpW =
    (COUNT_BITS > bdpc_pkg::CfgW) ? COUNT_BITS : bdpc_pkg::CfgW;

  logic                      s_acc, m_acc;

  logic [bdpc_pkg::CfgW-1:0] debounce_ticks_q, long_ticks_q, xlong_ticks_q;
  logic                      active_level_q;

  logic                      stable_q, stable_d;
  logic                      in_db_q, in_db_d;
  logic [COUNT_BITS-1:0]     db_cnt_q, db_cnt_d, db_inc;
  logic [COUNT_BITS-1:0]     press_cnt_q, press_cnt_d, press_inc;
  logic                      pressed;
  bdpc_pkg::press_class_e    cls_d, cls_q;
  logic                      out_valid_q;

  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_acc         = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ticks_q <= bdpc_pkg::DEBOUNCE_TICKS_RST;
      long_ticks_q     <= bdpc_pkg::LONG_PRESS_TICKS_RST;
      xlong_ticks_q    <= bdpc_pkg::XLONG_PRESS_TICKS_RST;
      active_level_q   <= bdpc_pkg::ACTIVE_LEVEL_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        bdpc_pkg::CFG_DEBOUNCE_TICKS:    debounce_ticks_q <= cfg_data_i;
        bdpc_pkg::CFG_LONG_PRESS_TICKS:  long_ticks_q     <= cfg_data_i;
        bdpc_pkg::CFG_XLONG_PRESS_TICKS: xlong_ticks_q    <= cfg_data_i;
        bdpc_pkg::CFG_ACTIVE_LEVEL:      active_level_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Saturating increments
  assign db_inc    = (&db_cnt_q)    ? db_cnt_q    : db_cnt_q + COUNT_BITS'(1);
  assign press_inc = (&press_cnt_q) ? press_cnt_q : press_cnt_q + COUNT_BITS'(1);

  assign pressed = (s_axis_tdata[0] == active_level_q);

  // Debounce window
  always_comb begin
    stable_d = stable_q;
    in_db_d  = in_db_q;
    db_cnt_d = db_cnt_q;
    if (!in_db_q && (pressed != stable_q)) begin
      in_db_d  = 1'b1;
      db_cnt_d = '0;
    end else if (in_db_q) begin
      db_cnt_d = db_inc;
      if (CmpW'(db_inc) < CmpW'(debounce_ticks_q)) begin
        // level went back before the window elapsed: drop it
        if (pressed == stable_q) in_db_d = 1'b0;
      end else begin
        in_db_d  = 1'b0;
        stable_d = pressed;
      end
    end
  end

  // Press duration and classification on an accepted edge
  always_comb begin
    press_cnt_d = press_inc;
    cls_d       = bdpc_pkg::CLS_NONE;
    if (stable_d != stable_q) begin
      if (stable_d) begin
        press_cnt_d = '0;
      end else if (CmpW'(press_inc) > CmpW'(xlong_ticks_q)) begin
        cls_d = bdpc_pkg::CLS_XLONG;
      end else if (CmpW'(press_inc) > CmpW'(long_ticks_q)) begin
        cls_d = bdpc_pkg::CLS_LONG;
      end else begin
        cls_d = bdpc_pkg::CLS_SHORT;
      end
    end
  end

  // State registers, advanced once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q    <= 1'b0;
      in_db_q     <= 1'b0;
      db_cnt_q    <= '0;
      press_cnt_q <= '0;
    end else if (s_acc) begin
      stable_q    <= stable_d;
      in_db_q     <= in_db_d;
      db_cnt_q    <= db_cnt_d;
      press_cnt_q <= press_cnt_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) cls_q <= cls_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(bdpc_pkg::OutDataW-2){1'b0}}, cls_q};

  // An accepted press restarts the duration count
  a_press_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && stable_d && !stable_q) |=> (press_cnt_q == '0))
    else $error("press count not cleared on accepted press");

  // An accepted release always yields a class on the next output
  a_release_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && !stable_d && stable_q) |=>
      (m_axis_tvalid && (cls_q != bdpc_pkg::CLS_NONE)))
    else $error("release not reported");

  // The stable state only changes at the end of an open window
  a_stable_via_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stable_q != $past(stable_q)) |-> $past(in_db_q))
    else $error("stable state changed without a debounce window");

endmodule

// File: test/tb.sv
module tb;

  localparam int unsigned CntW       = bdpc_pkg::CountBitsDef;
  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned RandTicks  = 760;

  typedef struct packed {
    logic [bdpc_pkg::CfgIdxW-1:0] idx;
    logic [bdpc_pkg::CfgW-1:0]    data;
  } reg_write_t;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [bdpc_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [bdpc_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          cfg_valid_i   = 1'b0;
  logic                          cfg_ready_o;
  logic [bdpc_pkg::CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [bdpc_pkg::CfgW-1:0]     cfg_data_i    = '0;

  // pending stimulus and expected classes
  bit                     tick_q[$];
  reg_write_t             write_q[$];
  bdpc_pkg::press_class_e class_q[$];

  int unsigned pushed_cnt  = 0;  // ticks queued by the sequence
  int unsigned sent_cnt    = 0;  // ticks put on the bus
  int unsigned checked_cnt = 0;  // results received
  int unsigned reg_cnt     = 0;  // register writes queued
  int unsigned reg_done    = 0;  // register writes accepted
  int unsigned phase_cnt   = 0;
  int unsigned fail_cnt    = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned seen_cls[4] = '{default: 0};

  // mirror of the classifier: settings and state
  logic [bdpc_pkg::CfgW-1:0] win_len   = bdpc_pkg::DEBOUNCE_TICKS_RST;
  logic [bdpc_pkg::CfgW-1:0] long_thr  = bdpc_pkg::LONG_PRESS_TICKS_RST;
  logic [bdpc_pkg::CfgW-1:0] xlong_thr = bdpc_pkg::XLONG_PRESS_TICKS_RST;
  logic                      press_lvl = bdpc_pkg::ACTIVE_LEVEL_RST;
  logic                      cur_pressed = 1'b0;
  logic                      in_window   = 1'b0;
  logic [CntW-1:0]           window_cnt  = '0;
  logic [CntW-1:0]           hold_len    = '0;

  button_debounce_press_classifier DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // one tick through the debouncer; returns the class reported on it
  function automatic bdpc_pkg::press_class_e classify_tick(logic raw);
    logic                   pressed;
    logic                   was_pressed;
    bdpc_pkg::press_class_e cls;
    pressed     = (raw == press_lvl);
    was_pressed = cur_pressed;
    cls         = bdpc_pkg::CLS_NONE;
    if (!in_window && pressed != cur_pressed) begin
      in_window  = 1'b1;
      window_cnt = '0;
    end else if (in_window) begin
      if (window_cnt != '1) window_cnt = window_cnt + 1'b1;
      if (window_cnt < win_len) begin
        // glitch over: level back at the stable value
        if (pressed == cur_pressed) in_window = 1'b0;
      end else begin
        in_window   = 1'b0;
        cur_pressed = pressed;
      end
    end
    if (hold_len != '1) hold_len = hold_len + 1'b1;
    if (cur_pressed != was_pressed) begin
      if (cur_pressed) hold_len = '0;
      else if (hold_len > xlong_thr) cls = bdpc_pkg::CLS_XLONG;
      else if (hold_len > long_thr) cls = bdpc_pkg::CLS_LONG;
      else cls = bdpc_pkg::CLS_SHORT;
    end
    return cls;
  endfunction

  function automatic void apply_reg(logic [bdpc_pkg::CfgIdxW-1:0] idx,
                                    logic [bdpc_pkg::CfgW-1:0] data);
    case (idx)
      bdpc_pkg::CFG_DEBOUNCE_TICKS:    win_len   = data;
      bdpc_pkg::CFG_LONG_PRESS_TICKS:  long_thr  = data;
      bdpc_pkg::CFG_XLONG_PRESS_TICKS: xlong_thr = data;
      bdpc_pkg::CFG_ACTIVE_LEVEL:      press_lvl = data[0];
      default: ;
    endcase
  endfunction

  // tick driver: bursts of random length, random gaps between them
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  always @(posedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (gap_left > 0 || tick_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= bdpc_pkg::InDataW'(tick_q.pop_front());
        sent_cnt++;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // register write driver
  always @(posedge clk_i) begin
    if (rst_ni && (!cfg_valid_i || cfg_ready_o)) begin
      if (write_q.size() != 0) begin
        reg_write_t w;
        w = write_q.pop_front();
        cfg_valid_i <= 1'b1;
        cfg_index_i <= w.idx;
        cfg_data_i  <= w.data;
      end else begin
        cfg_valid_i <= 1'b0;
      end
    end
  end

  // long hold-off on the result side while ticks keep coming
  int unsigned hold_left  = 0;
  int unsigned holds_done = 0;
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && sent_cnt > 100 && tick_q.size() > 60) begin
      hold_left  <= 300;
      holds_done <= holds_done + 1;
    end
  end

  // result side stall pattern, renewed each time the 6-bit age counter wraps
  logic [15:0] stall_pat = '0;
  logic [5:0]  pat_age   = '0;
  always @(posedge clk_i) begin
    if (pat_age == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pat = '0;
        1:       stall_pat = 16'($urandom & $urandom);
        2:       stall_pat = 16'($urandom);
        default: stall_pat = 16'($urandom & $urandom & $urandom);
      endcase
    end
    pat_age = pat_age + 1'b1;
    m_axis_tready <= rst_ni && (hold_left == 0) && !stall_pat[pat_age[3:0]];
  end

  // monitor: mirror register writes, predict on accepted ticks, check results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        apply_reg(cfg_index_i, cfg_data_i);
        reg_done++;
      end
      if (s_axis_tvalid && s_axis_tready) class_q.push_back(classify_tick(s_axis_tdata[0]));
      if (m_axis_tvalid && m_axis_tready) begin
        checked_cnt++;
        seen_cls[m_axis_tdata[1:0]]++;
        if (class_q.size() == 0) begin
          $error("press_class: no expectation waiting, got %0d", m_axis_tdata[1:0]);
          fail_cnt++;
        end else begin
          bdpc_pkg::press_class_e want;
          want = class_q.pop_front();
          if (m_axis_tdata[1:0] != want) begin
            $error("press_class: expected %0d, got %0d", want, m_axis_tdata[1:0]);
            fail_cnt++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic add_ticks(bit lvl, int unsigned n);
    repeat (n) tick_q.push_back(lvl);
    pushed_cnt += n;
  endtask

  task automatic write_reg(logic [bdpc_pkg::CfgIdxW-1:0] idx, logic [bdpc_pkg::CfgW-1:0] data);
    write_q.push_back('{idx: idx, data: data});
    reg_cnt++;
  endtask

  // wait for every write and every result, then let the pipeline empty
  task automatic drain();
    while (checked_cnt != pushed_cnt || reg_done != reg_cnt) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    phase_cnt++;
  endtask

  // one press with optional contact bounce on both edges
  task automatic add_gesture(bit on_lvl, int unsigned win);
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 4)) add_ticks(1'($urandom), $urandom_range(1, win + 1));
    if ($urandom_range(0, 5) == 0)
      add_ticks(on_lvl, $urandom_range(1, win + 1));  // may be too short to count
    else
      add_ticks(on_lvl, $urandom_range(win + 1, win + 45));
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 4)) add_ticks(1'($urandom), $urandom_range(1, win + 1));
    add_ticks(!on_lvl, $urandom_range(win + 1, win + 12));
  endtask

  function automatic logic [bdpc_pkg::CfgW-1:0] pick_thr(int unsigned hi);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return bdpc_pkg::CfgW'($urandom_range(0, hi));
    endcase
  endfunction

  initial begin
    int unsigned rand_base;
    int unsigned phase_base;
    int unsigned win;
    bit          on_lvl;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // defaults: active low, ten tick window; a short glitch is dropped
    add_ticks(1, 2);
    add_ticks(0, 3);
    add_ticks(1, 2);
    drain();

    // zero window, thresholds at both ends, active high; unknown indices ignored
    write_reg(bdpc_pkg::CFG_DEBOUNCE_TICKS, '0);
    write_reg(bdpc_pkg::CFG_LONG_PRESS_TICKS, '0);
    write_reg(bdpc_pkg::CFG_XLONG_PRESS_TICKS, '1);
    write_reg(bdpc_pkg::CFG_ACTIVE_LEVEL, '1);
    write_reg('1, '0);
    write_reg(bdpc_pkg::CfgIdxW'(4), 16'h5a5a);
    drain();
    add_ticks(1, 3);
    add_ticks(0, 3);
    add_ticks(1, 1);  // change seen, then level back before acceptance
    add_ticks(0, 2);
    drain();

    // extra long threshold at zero; upper data bits of active level dropped
    write_reg(bdpc_pkg::CFG_DEBOUNCE_TICKS, bdpc_pkg::CfgW'(1));
    write_reg(bdpc_pkg::CFG_LONG_PRESS_TICKS, '1);
    write_reg(bdpc_pkg::CFG_XLONG_PRESS_TICKS, '0);
    write_reg(bdpc_pkg::CFG_ACTIVE_LEVEL, 16'hfffe);
    drain();
    add_ticks(0, 4);
    add_ticks(1, 3);
    drain();

    // widest window: the change stays pending
    write_reg(bdpc_pkg::CFG_DEBOUNCE_TICKS, '1);
    drain();
    add_ticks(0, 3);
    drain();

    // random settings, mostly well formed presses with bounce
    rand_base = pushed_cnt;
    while (pushed_cnt - rand_base < RandTicks) begin
      win    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      on_lvl = 1'($urandom);
      write_reg(bdpc_pkg::CFG_DEBOUNCE_TICKS, bdpc_pkg::CfgW'(win));
      write_reg(bdpc_pkg::CFG_LONG_PRESS_TICKS, pick_thr(30));
      write_reg(bdpc_pkg::CFG_XLONG_PRESS_TICKS, pick_thr(60));
      write_reg(bdpc_pkg::CFG_ACTIVE_LEVEL, bdpc_pkg::CfgW'($urandom));
      if ($urandom_range(0, 3) == 0)
        write_reg(bdpc_pkg::CfgIdxW'($urandom_range(4, 255)), bdpc_pkg::CfgW'($urandom));
      drain();
      phase_base = pushed_cnt;
      while (pushed_cnt - phase_base < 140) begin
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(1, 8)) add_ticks(1'($urandom), 1);
        else
          add_gesture(on_lvl, win);
      end
      drain();
    end
    repeat (20) @(posedge clk_i);

    $display("%0d ticks over %0d phases, %0d register writes, receiver held off %0d times",
             checked_cnt, phase_cnt, reg_done, holds_done);
    $display("releases seen: %0d short, %0d long, %0d extra long",
             seen_cls[bdpc_pkg::CLS_SHORT], seen_cls[bdpc_pkg::CLS_LONG],
             seen_cls[bdpc_pkg::CLS_XLONG]);
    if (fail_cnt == 0 && class_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: files.f
sv/bdpc_pkg.sv
sv/button_debounce_press_classifier.sv
test/tb.sv
